[rtl/core/rrtsq_pkg.sv]
`default_nettype none

package rrtsq_pkg;

    // Fixed field widths of the transfer payloads and the register port.
    localparam int OPCODE_W  = 2;
    localparam int TASK_ID_W = 4;
    localparam int QLEN_W    = 5;
    localparam int ERR_W     = 2;
    localparam int CFG_W     = 16;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [CFG_W-1:0] SLICE_TICKS_RESET = 16'd10;

    // Register index as decoded from the word address.
    localparam logic [0:0] REG_SLICE_TICKS = 1'b0;

    // Halves of the link memory.
    localparam logic LINK_NEXT = 1'b0;
    localparam logic LINK_PREV = 1'b1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_TICK = 2'd2
    } t_opcode;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK     = 2'd0,
        ERR_DUP    = 2'd1,
        ERR_ABSENT = 2'd2
    } t_err;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_UL_A,
        S_UL_B,
        S_UL_C,
        S_LK_A,
        S_LK_B,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

[rtl/core/rrtsq_in_if.sv]
`default_nettype none

interface rrtsq_in_if;
    logic                           valid;
    logic                           ready;
    logic [rrtsq_pkg::OPCODE_W-1:0]  opcode;
    logic [rrtsq_pkg::TASK_ID_W-1:0] task_id;

    modport source (output valid, output opcode, output task_id, input ready);
    modport sink   (input valid, input opcode, input task_id, output ready);
endinterface

`default_nettype wire

[rtl/core/rrtsq_out_if.sv]
`default_nettype none

interface rrtsq_out_if;
    logic                           valid;
    logic                           ready;
    logic [rrtsq_pkg::TASK_ID_W-1:0] head_task;
    logic                           head_valid;
    logic [rrtsq_pkg::QLEN_W-1:0]    queue_length;
    logic                           resched;
    logic [rrtsq_pkg::ERR_W-1:0]     error_code;

    modport source (
        output valid, output head_task, output head_valid, output queue_length,
        output resched, output error_code, input ready
    );
    modport sink (
        input valid, input head_task, input head_valid, input queue_length,
        input resched, input error_code, output ready
    );
endinterface

`default_nettype wire

[rtl/core/rrtsq_ram.sv]
`default_nettype none

module rrtsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/rrtsq_cfg.sv]
`default_nettype none

module rrtsq_cfg #(
    parameter int SLICE_BITS = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [rrtsq_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [rrtsq_pkg::PDATA_W-1:0]    pwdata,
    output logic      [rrtsq_pkg::PDATA_W-1:0]    prdata,
    output logic                                  pready,
    output logic      [SLICE_BITS-1:0]            o_reload
);

    import rrtsq_pkg::*;

    localparam logic [63:0] SLICE_MAX = (64'd1 << SLICE_BITS) - 64'd1;

    logic [CFG_W-1:0] r_slice_ticks;
    logic             w_sel_slice;

    assign w_sel_slice = (paddr[2:2] == REG_SLICE_TICKS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_ticks <= SLICE_TICKS_RESET;
        end else if (psel && penable && pwrite && w_sel_slice) begin
            r_slice_ticks <= pwdata[CFG_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = w_sel_slice ? PDATA_W'(r_slice_ticks) : '0;

    // The reload value saturates to the width of the slice counters.
    assign o_reload = (64'(r_slice_ticks) > SLICE_MAX) ? SLICE_MAX[SLICE_BITS-1:0]
                                                       : SLICE_BITS'(r_slice_ticks);

endmodule

`default_nettype wire

[rtl/core/rrtsq_ctrl.sv]
`default_nettype none

module rrtsq_ctrl #(
    parameter int MAX_TASKS  = 16,
    parameter int SLICE_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [SLICE_BITS-1:0] i_reload,
    rrtsq_in_if.sink                   i_in,
    rrtsq_out_if.source                o_out
);

    import rrtsq_pkg::*;

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int TW = SLICE_BITS + 1;

    t_state           r_state, n_state;
    logic [OPCODE_W-1:0] r_op, n_op;
    logic [IW-1:0]    r_tid, n_tid;
    logic             r_in_range, n_in_range;
    logic [IW-1:0]    r_head, n_head;
    logic [IW-1:0]    r_tail, n_tail;
    logic [CW-1:0]    r_count, n_count;
    logic [IW-1:0]    r_p, n_p;
    logic [IW-1:0]    r_n, n_n;
    t_err             r_err, n_err;
    logic             r_resched, n_resched;
    logic [IW-1:0]    r_clr, n_clr;

    logic                r_out_valid;
    logic [TASK_ID_W-1:0] r_out_head;
    logic                r_out_hv;
    logic [QLEN_W-1:0]   r_out_len;
    logic                r_out_resched;
    logic [ERR_W-1:0]    r_out_err;
    logic                w_out_load;

    logic [31:0]         w_tid_ext;
    logic [IW-1:0]       w_in_idx;
    logic                w_in_range;
    logic [31:0]         w_head_ext;
    logic [31:0]         w_count_ext;

    logic                w_q;
    logic [SLICE_BITS-1:0] w_s;

    logic                task_we;
    logic [IW-1:0]       task_waddr;
    logic [TW-1:0]       task_wdata;
    logic [IW-1:0]       task_raddr;
    logic [TW-1:0]       task_rdata;

    logic                link_we;
    logic [IW:0]         link_waddr;
    logic [IW-1:0]       link_wdata;
    logic [IW:0]         link_raddr;
    logic [IW-1:0]       link_rdata;

    // Per-task queued flag and slice counter.
    rrtsq_ram #(.WIDTH(TW), .DEPTH(MAX_TASKS)) u_task_ram (
        .i_clk   (i_clk),
        .i_we    (task_we),
        .i_waddr (task_waddr),
        .i_wdata (task_wdata),
        .i_raddr (task_raddr),
        .o_rdata (task_rdata)
    );

    // Next links in the lower half, previous links in the upper half. Each half spans the full
    // index range, so the half select bit lands on a valid entry for any task count.
    rrtsq_ram #(.WIDTH(IW), .DEPTH(2 << IW)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    assign w_tid_ext  = 32'(i_in.task_id);
    assign w_in_idx   = w_tid_ext[IW-1:0];
    assign w_in_range = (w_tid_ext < 32'(MAX_TASKS));
    assign w_q        = task_rdata[SLICE_BITS];
    assign w_s        = task_rdata[SLICE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_clr     <= '0;
            r_op      <= '0;
            r_in_range <= 1'b0;
            r_err     <= ERR_OK;
            r_resched <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_clr     <= n_clr;
            r_op      <= n_op;
            r_in_range <= n_in_range;
            r_err     <= n_err;
            r_resched <= n_resched;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tid <= n_tid;
        r_p   <= n_p;
        r_n   <= n_n;
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_tid      = r_tid;
        n_in_range = r_in_range;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_p        = r_p;
        n_n        = r_n;
        n_err      = r_err;
        n_resched  = r_resched;
        n_clr      = r_clr;
        task_we    = 1'b0;
        task_waddr = r_tid;
        task_wdata = '0;
        task_raddr = w_in_idx;
        link_we    = 1'b0;
        link_waddr = {LINK_NEXT, r_tid};
        link_wdata = r_tid;
        link_raddr = {LINK_PREV, r_tid};
        i_in.ready = 1'b0;
        w_out_load = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                task_we    = 1'b1;
                task_waddr = r_clr;
                n_clr      = r_clr + IW'(1);
                if (r_clr == IW'(MAX_TASKS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_op       = i_in.opcode;
                    n_tid      = w_in_idx;
                    n_in_range = w_in_range;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                n_err     = ERR_OK;
                n_resched = 1'b0;
                n_state   = S_DONE;
                unique case (r_op)
                    OP_ENQ: begin
                        if (!r_in_range) begin
                            n_err = ERR_ABSENT;
                        end else if (w_q) begin
                            n_err = ERR_DUP;
                        end else begin
                            task_we    = 1'b1;
                            task_wdata = {1'b1, i_reload};
                            n_state    = S_LK_A;
                        end
                    end
                    OP_DEQ: begin
                        if (!r_in_range || !w_q) begin
                            n_err = ERR_ABSENT;
                        end else begin
                            task_we    = 1'b1;
                            task_wdata = {1'b0, w_s};
                            if (r_count <= CW'(1)) begin
                                n_head  = '0;
                                n_tail  = '0;
                                n_count = '0;
                            end else begin
                                n_state = S_UL_A;
                            end
                        end
                    end
                    OP_TICK: begin
                        if (r_in_range) begin
                            task_we = 1'b1;
                            if (w_s > SLICE_BITS'(1)) begin
                                task_wdata = {w_q, w_s - SLICE_BITS'(1)};
                            end else begin
                                task_wdata = {w_q, i_reload};
                                n_resched  = 1'b1;
                                if (w_q && (r_tail != r_tid)) begin
                                    n_state = S_UL_A;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_UL_A: begin
                n_p        = link_rdata;
                link_raddr = {LINK_NEXT, r_tid};
                n_state    = S_UL_B;
            end
            S_UL_B: begin
                n_n = link_rdata;
                if (r_head == r_tid) begin
                    n_head = link_rdata;
                end else begin
                    link_we    = 1'b1;
                    link_waddr = {LINK_NEXT, r_p};
                    link_wdata = link_rdata;
                end
                n_state = S_UL_C;
            end
            S_UL_C: begin
                if (r_tail == r_tid) begin
                    n_tail = r_p;
                end else begin
                    link_we    = 1'b1;
                    link_waddr = {LINK_PREV, r_n};
                    link_wdata = r_p;
                end
                n_count = r_count - CW'(1);
                n_state = (r_op == OP_TICK) ? S_LK_A : S_DONE;
            end
            S_LK_A: begin
                if (r_count == '0) begin
                    n_head = r_tid;
                end else begin
                    link_we    = 1'b1;
                    link_waddr = {LINK_NEXT, r_tail};
                    link_wdata = r_tid;
                end
                n_state = S_LK_B;
            end
            S_LK_B: begin
                if (r_count != '0) begin
                    link_we    = 1'b1;
                    link_waddr = {LINK_PREV, r_tid};
                    link_wdata = r_tail;
                end
                n_tail  = r_tid;
                n_count = r_count + CW'(1);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
        endcase
    end

    assign w_head_ext  = 32'(r_head);
    assign w_count_ext = 32'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_head    <= (r_count != '0) ? w_head_ext[TASK_ID_W-1:0] : '0;
            r_out_hv      <= (r_count != '0);
            r_out_len     <= w_count_ext[QLEN_W-1:0];
            r_out_resched <= r_resched;
            r_out_err     <= r_err;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.head_task    = r_out_head;
    assign o_out.head_valid   = r_out_hv;
    assign o_out.queue_length = r_out_len;
    assign o_out.resched      = r_out_resched;
    assign o_out.error_code   = r_out_err;

endmodule

`default_nettype wire

[rtl/core/round_robin_time_slice_queue.sv]
`default_nettype none

// Round-robin run queue of task identifiers with a time slice per task. Each input transfer
// carries an opcode (enqueue, dequeue or tick for the running task) and a task identifier, and
// produces exactly one result transfer giving the head task, the queue length, a reschedule
// flag and an error code. The queue is a doubly linked list held in a link memory with one
// read port and one write port (next links and previous links in two halves), and the queued
// flags and slice counters sit in a second memory; both have a registered read. The link
// memory, which takes at most one read and one write a cycle, sets the timing: an item that
// touches no links (errors, ticks that move nothing, unused opcodes and the dequeue of the
// only queued task) passes the read and done states only, an enqueue also the link states,
// a dequeue from a queue of two or more the unlink states and a tick that moves a task to
// the tail the unlink and then the link states, provided the result register is free. A
// finished result waits in its output register, and the next input is taken while it
// waits. After reset the block sweeps the task memory to clear all flags and counters; no
// input is accepted during the sweep, although the slice_ticks register may be written at
// any time through the APB port.

module round_robin_time_slice_queue #(
    parameter int MAX_TASKS  = 16,
    parameter int SLICE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    rrtsq_in_if.sink                           i_in,
    rrtsq_out_if.source                        o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rrtsq_pkg::PADDR_W-1:0] paddr,
    input  wire logic [rrtsq_pkg::PDATA_W-1:0] pwdata,
    output logic      [rrtsq_pkg::PDATA_W-1:0] prdata,
    output logic                               pready
);

    import rrtsq_pkg::*;

    // Reload value for the slice counters, already saturated to SLICE_BITS.
    logic [SLICE_BITS-1:0] w_reload;

    // Holds slice_ticks, which the user writes only while the queue is idle; not enforced.
    rrtsq_cfg #(.SLICE_BITS(SLICE_BITS)) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_reload (w_reload)
    );

    // The sequencer reads each task's entry, works out the change and writes the links back
    // one entry at a time; the steps of one item never overlap with those of the next, so no
    // forwarding between memory accesses is needed.
    rrtsq_ctrl #(.MAX_TASKS(MAX_TASKS), .SLICE_BITS(SLICE_BITS)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_reload (w_reload),
        .i_in     (i_in),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire
